>>> rtl/core/pdh_pkg.sv
// Shared types, widths and codes of the pair distance histogram unit.
`timescale 1ns / 1ps
package pdh_pkg;

    localparam int BIN_COUNT_DEF = 16;
    localparam int COORD_BITS    = 24;
    localparam int EDGE_BITS     = COORD_BITS + 1;
    localparam int AXIS_SQ_BITS  = 2 * COORD_BITS;
    localparam int SQ_BITS       = 2 * EDGE_BITS;
    localparam int COUNT_BITS    = 32;
    localparam int IDX_BITS      = 4;
    localparam int CFG_BITS      = 5;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_PAIR  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] CLS_DD = 2'd0;
    localparam logic [1:0] CLS_DR = 2'd1;
    localparam logic [1:0] CLS_RR = 2'd2;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [IDX_BITS-1:0]          bin_index;
        logic [EDGE_BITS-1:0]         edge_low;
        logic [EDGE_BITS-1:0]         edge_high;
        logic [1:0]                   pair_class;
        logic signed [COORD_BITS-1:0] point_a_x;
        logic signed [COORD_BITS-1:0] point_a_y;
        logic signed [COORD_BITS-1:0] point_a_z;
        logic signed [COORD_BITS-1:0] point_b_x;
        logic signed [COORD_BITS-1:0] point_b_y;
        logic signed [COORD_BITS-1:0] point_b_z;
    } t_in_item;

    typedef struct packed {
        logic                  bin_found;
        logic [IDX_BITS-1:0]   bin_hit;
        logic [COUNT_BITS-1:0] dd_count;
        logic [COUNT_BITS-1:0] dr_count;
        logic [COUNT_BITS-1:0] rr_count;
    } t_out_item;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_BITS-1:0]     bin_index;
        logic [1:0]              pair_class;
        logic [SQ_BITS-1:0]      low_sq;
        logic [SQ_BITS-1:0]      high_sq;
        logic [AXIS_SQ_BITS-1:0] sq_x;
        logic [AXIS_SQ_BITS-1:0] sq_y;
        logic [AXIS_SQ_BITS-1:0] sq_z;
    } t_sq_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic [IDX_BITS-1:0] bin_index;
        logic [1:0]          pair_class;
        logic [SQ_BITS-1:0]  low_sq;
        logic [SQ_BITS-1:0]  high_sq;
        logic [SQ_BITS-1:0]  dist_sq;
    } t_dist_item;

endpackage

>>> rtl/core/pdh_sqdist.sv
// Per-axis squared differences and squared bin edges of one item.
`timescale 1ns / 1ps
module pdh_sqdist
    import pdh_pkg::*;
(
    input  t_in_item i_item,
    output t_sq_item o_item
);

    // The difference of two coordinates of COORD_BITS bits has a magnitude
    // that always fits in COORD_BITS unsigned bits.
    function automatic logic [COORD_BITS-1:0] axis_mag(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] nd;
        d  = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
        nd = -d;
        return d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] mag_x, mag_y, mag_z;

    always_comb begin
        mag_x = axis_mag(i_item.point_a_x, i_item.point_b_x);
        mag_y = axis_mag(i_item.point_a_y, i_item.point_b_y);
        mag_z = axis_mag(i_item.point_a_z, i_item.point_b_z);

        o_item.kind       = i_item.kind;
        o_item.bin_index  = i_item.bin_index;
        o_item.pair_class = i_item.pair_class;
        o_item.sq_x = {{COORD_BITS{1'b0}}, mag_x} * {{COORD_BITS{1'b0}}, mag_x};
        o_item.sq_y = {{COORD_BITS{1'b0}}, mag_y} * {{COORD_BITS{1'b0}}, mag_y};
        o_item.sq_z = {{COORD_BITS{1'b0}}, mag_z} * {{COORD_BITS{1'b0}}, mag_z};
        o_item.low_sq  = {{EDGE_BITS{1'b0}}, i_item.edge_low}
                       * {{EDGE_BITS{1'b0}}, i_item.edge_low};
        o_item.high_sq = {{EDGE_BITS{1'b0}}, i_item.edge_high}
                       * {{EDGE_BITS{1'b0}}, i_item.edge_high};
    end

endmodule

>>> rtl/core/pdh_bin_bank.sv
// Bin edge and count registers with the parallel bin search and update.
`timescale 1ns / 1ps
module pdh_bin_bank
    import pdh_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_dist_item          i_item,
    input  logic [CFG_BITS-1:0] i_bins_in_use,
    output t_out_item           o_result
);

    localparam int HIT_BITS = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    logic [SQ_BITS-1:0]    r_low_sq  [BIN_COUNT];
    logic [SQ_BITS-1:0]    r_high_sq [BIN_COUNT];
    logic [COUNT_BITS-1:0] r_dd      [BIN_COUNT];
    logic [COUNT_BITS-1:0] r_dr      [BIN_COUNT];
    logic [COUNT_BITS-1:0] r_rr      [BIN_COUNT];

    logic [BIN_COUNT-1:0]  in_range;
    logic                  found;
    logic [HIT_BITS-1:0]   hit;
    logic [HIT_BITS-1:0]   sel;
    logic                  addr_ok;
    logic                  is_pair;
    logic                  report_ok;
    logic [COUNT_BITS-1:0] n_dd, n_dr, n_rr;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] c,
        input logic [1:0]            inc
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + (COUNT_BITS+1)'(inc);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    always_comb begin
        for (int k = 0; k < BIN_COUNT; k++) begin
            in_range[k] = (k < int'(i_bins_in_use))
                        && (r_low_sq[k] <= i_item.dist_sq)
                        && (i_item.dist_sq <= r_high_sq[k]);
        end
        // Lowest matching bin wins.
        found = 1'b0;
        hit   = '0;
        for (int k = BIN_COUNT - 1; k >= 0; k--) begin
            if (in_range[k]) begin
                found = 1'b1;
                hit   = HIT_BITS'(k);
            end
        end

        is_pair = (i_item.kind == KIND_PAIR);
        addr_ok = int'(i_item.bin_index) < BIN_COUNT;
        sel     = is_pair ? hit : HIT_BITS'(i_item.bin_index);

        n_dd = r_dd[sel];
        n_dr = r_dr[sel];
        n_rr = r_rr[sel];
        if (is_pair && found) begin
            case (i_item.pair_class)
                CLS_DD:  n_dd = sat_add(r_dd[sel], 2'd2);
                CLS_DR:  n_dr = sat_add(r_dr[sel], 2'd1);
                CLS_RR:  n_rr = sat_add(r_rr[sel], 2'd2);
                default: ;
            endcase
        end

        case (i_item.kind)
            KIND_PAIR:            report_ok = found;
            KIND_LOAD, KIND_READ: report_ok = addr_ok;
            default:              report_ok = 1'b0;
        endcase

        o_result.bin_found = is_pair && found;
        o_result.bin_hit   = is_pair ? IDX_BITS'(hit) : i_item.bin_index;
        o_result.dd_count  = report_ok ? n_dd : '0;
        o_result.dr_count  = report_ok ? n_dr : '0;
        o_result.rr_count  = report_ok ? n_rr : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BIN_COUNT; k++) begin
                r_low_sq[k]  <= '0;
                r_high_sq[k] <= '0;
                r_dd[k]      <= '0;
                r_dr[k]      <= '0;
                r_rr[k]      <= '0;
            end
        end else if (i_en) begin
            case (i_item.kind)
                KIND_LOAD: begin
                    for (int k = 0; k < BIN_COUNT; k++) begin
                        if (int'(i_item.bin_index) == k) begin
                            r_low_sq[k]  <= i_item.low_sq;
                            r_high_sq[k] <= i_item.high_sq;
                        end
                    end
                end
                KIND_PAIR: begin
                    if (found) begin
                        r_dd[hit] <= n_dd;
                        r_dr[hit] <= n_dr;
                        r_rr[hit] <= n_rr;
                    end
                end
                KIND_CLEAR: begin
                    for (int k = 0; k < BIN_COUNT; k++) begin
                        r_dd[k] <= '0;
                        r_dr[k] <= '0;
                        r_rr[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/pair_distance_histogram_unit.sv
// Top level of the pair distance histogram unit: pipeline and handshakes.
//
// Items arrive on the input channel (i_in_valid, o_in_ready, i_in_data) and
// every item produces exactly one result on the output channel
// (o_out_valid, i_out_ready, o_out_data). A pair item computes the squared
// separation of its two points and adds to the first bin in use whose
// squared edges contain it; load, read and clear items manage the bins.
// The bins_in_use register is written over its own channel (i_cfg_valid,
// o_cfg_ready, i_cfg_data), which is always ready; write it only while the
// unit is idle.
// A result is registered: each item passes the three register stages
// (squares, sum, bin search and update) and then the output register.
// Throughput is one item per cycle while the receiver is ready; each
// stage takes a new item whenever it is empty or its item moves on.
// All edge and count updates happen in the last stage in item order, so
// back-to-back items see each other's effects without hazards.
// Synchronous active-low reset empties the pipeline and zeroes all edges,
// counts and bins_in_use. When the receiver stalls, the output register
// holds its result and the stages behind it keep filling; input ready
// drops only once every stage holds an item.
`timescale 1ns / 1ps
module pair_distance_histogram_unit
    import pdh_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    t_in_item            r_s1;
    t_sq_item            r_s2;
    t_dist_item          r_s3;
    t_out_item           r_out;
    logic                r_v1, r_v2, r_v3, r_out_v;
    logic [CFG_BITS-1:0] r_bins_in_use;

    t_sq_item            n_s2;
    t_dist_item          n_s3;
    t_out_item           n_out;
    logic                en1, en2, en3, en_o;

    // A stage loads when it is empty or its item moves on this cycle.
    assign en_o = !r_out_v || i_out_ready;
    assign en3  = !r_v3 || en_o;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;

    assign o_in_ready  = en1;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    pdh_sqdist u_sqdist (
        .i_item (r_s1),
        .o_item (n_s2)
    );

    // The sum of three squares fits the squared edge width exactly.
    always_comb begin
        n_s3.kind       = r_s2.kind;
        n_s3.bin_index  = r_s2.bin_index;
        n_s3.pair_class = r_s2.pair_class;
        n_s3.low_sq     = r_s2.low_sq;
        n_s3.high_sq    = r_s2.high_sq;
        n_s3.dist_sq    = SQ_BITS'(r_s2.sq_x) + SQ_BITS'(r_s2.sq_y) + SQ_BITS'(r_s2.sq_z);
    end

    pdh_bin_bank #(
        .BIN_COUNT (BIN_COUNT)
    ) u_bin_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en_o && r_v3),
        .i_item        (r_s3),
        .i_bins_in_use (r_bins_in_use),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_out_v       <= 1'b0;
            r_bins_in_use <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_bins_in_use <= i_cfg_data;
            end
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en_o) begin
                r_out_v <= r_v3;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= i_in_data;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (en3) begin
            r_s3 <= n_s3;
        end
        if (en_o) begin
            r_out <= n_out;
        end
    end

endmodule
